@@ hw/rtl/genotype_byte_unpack_stats_top_defines.svh @@
// Assertion helpers for the checker file gbus_checker.sv.
`ifndef GENOTYPE_BYTE_UNPACK_STATS_TOP_DEFINES_SVH
`define GENOTYPE_BYTE_UNPACK_STATS_TOP_DEFINES_SVH

// same-cycle implication
`define GBUS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gbus check failed");

// next-cycle implication
`define GBUS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gbus check failed");

`endif

@@ hw/rtl/gbus_pkg.sv @@
`default_nettype none

package gbus_pkg;

   localparam int CNT_W     = 21;
   localparam int TOL_W     = 17;
   localparam int FREQ_W    = 17;
   localparam int BYTE_W    = 8;
   localparam int WORD_BITS = 64;
   localparam int WNUM_W    = 14;
   localparam int SUM_W     = 22;
   localparam int SQ_W      = 23;
   localparam int SPREAD_W  = 41;
   localparam int STATUS_W  = 2;
   localparam int PROD_W    = CNT_W + SQ_W;
   localparam int FN_W      = FREQ_W + CNT_W;
   localparam int CROSS_W   = FN_W + 1;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [1:0] code_type;
   localparam code_type CODE_HOM_MAJOR = 2'd0;
   localparam code_type CODE_MISSING   = 2'd1;
   localparam code_type CODE_HET       = 2'd2;
   localparam code_type CODE_HOM_MINOR = 2'd3;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_KEPT         = 2'd0;
   localparam status_type STATUS_ALL_MISSING  = 2'd1;
   localparam status_type STATUS_MISMATCH     = 2'd2;
   localparam status_type STATUS_NO_VARIATION = 2'd3;

   localparam logic KIND_WORD    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic REG_INDIVIDUAL_COUNT    = 1'b0;
   localparam logic REG_FREQUENCY_TOLERANCE = 1'b1;

   typedef struct packed {
      logic [WORD_BITS-1:0] a1;
      logic [WORD_BITS-1:0] a2;
      logic [WNUM_W-1:0]    num;
   } word_type;

   typedef struct packed {
      logic [CNT_W-1:0] n;
      logic [SUM_W-1:0] s;
      logic [SQ_W-1:0]  q;
   } stats_type;

endpackage

`default_nettype wire

@@ hw/rtl/genotype_byte_unpack_stats_top.sv @@
// Path: input register, stage 1, stage 2, output register; a variant-ending request gives a word, then a summary.
// Throughput: one request per cycle while req_stall is low; the result port moves one
// result per cycle unless stalled; a variant-ending request holds the output register for both.
// Reset: synchronous, active high; clears the pipeline, variant state and registers
// (individual_count 1, frequency_tolerance 13107). No clearing pass.
`default_nettype none

module genotype_byte_unpack_stats_top #(
   parameter int MAX_INDIVIDUALS = 1048576
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gbus_pkg::BYTE_W-1:0]       req_genotype_byte,
   input  logic                              req_swap_alleles,
   input  logic [gbus_pkg::FREQ_W-1:0]       req_reference_frequency,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_result_kind,
   output logic [gbus_pkg::WORD_BITS-1:0]    rsp_plane_a1_word,
   output logic [gbus_pkg::WORD_BITS-1:0]    rsp_plane_a2_word,
   output logic [gbus_pkg::WNUM_W-1:0]       rsp_word_number,
   output logic [gbus_pkg::STATUS_W-1:0]     rsp_variant_status,
   output logic [gbus_pkg::SUM_W-1:0]        rsp_dosage_sum,
   output logic [gbus_pkg::SQ_W-1:0]         rsp_dosage_square_sum,
   output logic [gbus_pkg::CNT_W-1:0]        rsp_present_count,
   output logic [gbus_pkg::SPREAD_W-1:0]     rsp_spread_value,
   output logic                              rsp_final_of_variant,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gbus_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [gbus_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [gbus_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import gbus_pkg::*;

   localparam int CNT_MAX = 2**CNT_W - 1;
   localparam logic [CNT_W-1:0] CNT_LIMIT =
      CNT_W'((MAX_INDIVIDUALS > CNT_MAX) ? CNT_MAX : MAX_INDIVIDUALS);

   // configuration
   logic [CNT_W-1:0] count_ff;
   logic [TOL_W-1:0] tol_ff;
   logic             csr_write;
   logic             reg_sel;

   // input register
   logic              v0_ff;
   logic [BYTE_W-1:0] byte0_ff;
   logic              swap0_ff;
   logic [FREQ_W-1:0] freq0_ff;

   // variant state
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [WORD_BITS-1:0] a1_ff, a1_in, a2_ff, a2_in;
   logic [WNUM_W-1:0]    wnum_ff, wnum_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [CNT_W-1:0]     pres_ff, pres_in;

   // stage 1
   logic              v1_ff, w1_ff, s1_ff;
   word_type          word1_ff;
   stats_type         stats1_ff;
   logic [FREQ_W-1:0] freq1_ff;

   // stage 2
   logic              v2_ff, w2_ff, s2_ff;
   word_type          word2_ff;
   stats_type         stats2_ff;
   logic [PROD_W-1:0] nq2_ff, ss2_ff;
   logic [FN_W-1:0]   fn2_ff, tn2_ff;

   // output register
   logic                pend_word_ff, pend_word_in;
   logic                pend_sum_ff, pend_sum_in;
   word_type            word3_ff;
   stats_type           stats3_ff;
   status_type          status3_ff;
   logic [SPREAD_W-1:0] spread3_ff;

   logic ready0, ready1, ready2, ready3;
   logic accept, fire0, load3, rsp_accept;

   // decode
   logic [CNT_W-1:0]     n_eff, remaining, new_pos;
   logic [2:0]           take;
   logic                 last, boundary, word_v;
   logic [3:0]           nib_a1, nib_a2;
   logic [3:0]           add_sum;
   logic [4:0]           add_sq;
   logic [2:0]           add_pres;
   logic [WORD_BITS-1:0] a1_upd, a2_upd;
   logic [SUM_W-1:0]     sum_upd;
   logic [SQ_W-1:0]      sq_upd;
   logic [CNT_W-1:0]     pres_upd;

   // summary
   logic [PROD_W-1:0]  nq, ss, spread_full;
   logic [FN_W-1:0]    fn, tn;
   logic [CROSS_W-1:0] lhs, rhs, diff, bound;
   status_type         status;

   // ---- configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_sel   = paddr[2];

   always_comb begin
      unique case (reg_sel)
         REG_INDIVIDUAL_COUNT:    prdata = CSR_DATA_W'(count_ff);
         REG_FREQUENCY_TOLERANCE: prdata = CSR_DATA_W'(tol_ff);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(1);
         tol_ff   <= TOL_W'(13107);
      end else if (csr_write) begin
         if (reg_sel == REG_INDIVIDUAL_COUNT) begin
            count_ff <= pwdata[CNT_W-1:0];
         end else begin
            tol_ff <= pwdata[TOL_W-1:0];
         end
      end
   end

   // ---- flow control
   assign rsp_valid  = pend_word_ff || pend_sum_ff;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign ready3     = !rsp_valid || (rsp_accept && !(pend_word_ff && pend_sum_ff));
   assign ready2     = !v2_ff || ready3;
   assign ready1     = !v1_ff || ready2;
   assign ready0     = !v0_ff || ready1;
   assign req_stall  = !ready0;
   assign accept     = req_valid && ready0;
   assign fire0      = v0_ff && ready1;
   assign load3      = v2_ff && ready3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (ready0) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte0_ff <= req_genotype_byte;
         swap0_ff <= req_swap_alleles;
         freq0_ff <= req_reference_frequency;
      end
   end

   // ---- decode and accumulate
   always_comb begin
      code_type code;
      if (count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (count_ff > CNT_LIMIT) begin
         n_eff = CNT_LIMIT;
      end else begin
         n_eff = count_ff;
      end
      remaining = n_eff - pos_ff;
      last      = remaining <= CNT_W'(4);
      take      = last ? remaining[2:0] : 3'd4;
      nib_a1    = '0;
      nib_a2    = '0;
      add_sum   = '0;
      add_sq    = '0;
      add_pres  = '0;
      for (int k = 0; k < 4; k++) begin
         code = byte0_ff[2*k +: 2];
         if (swap0_ff && (code == CODE_HOM_MAJOR || code == CODE_HOM_MINOR)) begin
            code = code ^ 2'b11;
         end
         if (3'(k) < take) begin
            unique case (code)
               CODE_HOM_MAJOR: begin
                  nib_a1[k] = 1'b1;
                  nib_a2[k] = 1'b1;
                  add_sum   = add_sum + 4'd2;
                  add_sq    = add_sq + 5'd4;
                  add_pres  = add_pres + 3'd1;
               end
               CODE_HET: begin
                  nib_a2[k] = 1'b1;
                  add_sum   = add_sum + 4'd1;
                  add_sq    = add_sq + 5'd1;
                  add_pres  = add_pres + 3'd1;
               end
               CODE_HOM_MINOR: begin
                  add_pres = add_pres + 3'd1;
               end
               CODE_MISSING: begin
                  nib_a1[k] = 1'b1;
               end
               default: begin
                  nib_a1[k] = 1'b0;
               end
            endcase
         end
      end
      new_pos  = pos_ff + CNT_W'(take);
      boundary = new_pos[5:0] == 6'd0;
      word_v   = boundary || last;
      a1_upd   = a1_ff | (WORD_BITS'(nib_a1) << {pos_ff[5:2], 2'b00});
      a2_upd   = a2_ff | (WORD_BITS'(nib_a2) << {pos_ff[5:2], 2'b00});
      sum_upd  = sum_ff + SUM_W'(add_sum);
      sq_upd   = sq_ff + SQ_W'(add_sq);
      pres_upd = pres_ff + CNT_W'(add_pres);
   end

   always_comb begin
      pos_in  = pos_ff;
      a1_in   = a1_ff;
      a2_in   = a2_ff;
      wnum_in = wnum_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      pres_in = pres_ff;
      if ((csr_write && reg_sel == REG_INDIVIDUAL_COUNT) || (fire0 && last)) begin
         pos_in  = '0;
         a1_in   = '0;
         a2_in   = '0;
         wnum_in = '0;
         sum_in  = '0;
         sq_in   = '0;
         pres_in = '0;
      end else if (fire0) begin
         pos_in  = new_pos;
         sum_in  = sum_upd;
         sq_in   = sq_upd;
         pres_in = pres_upd;
         if (boundary) begin
            a1_in   = '0;
            a2_in   = '0;
            wnum_in = wnum_ff + WNUM_W'(1);
         end else begin
            a1_in = a1_upd;
            a2_in = a2_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         a1_ff   <= '0;
         a2_ff   <= '0;
         wnum_ff <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
         pres_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         a1_ff   <= a1_in;
         a2_ff   <= a2_in;
         wnum_ff <= wnum_in;
         sum_ff  <= sum_in;
         sq_ff   <= sq_in;
         pres_ff <= pres_in;
      end
   end

   // ---- stage 1: one request's results
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         w1_ff <= 1'b0;
         s1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= fire0 && word_v;
         w1_ff <= word_v;
         s1_ff <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         word1_ff.a1    <= a1_upd;
         word1_ff.a2    <= a2_upd;
         word1_ff.num   <= wnum_ff;
         stats1_ff.n    <= pres_upd;
         stats1_ff.s    <= sum_upd;
         stats1_ff.q    <= sq_upd;
         freq1_ff       <= freq0_ff;
      end
   end

   // ---- stage 2: products
   assign nq = PROD_W'(stats1_ff.n) * PROD_W'(stats1_ff.q);
   assign ss = PROD_W'(stats1_ff.s) * PROD_W'(stats1_ff.s);
   assign fn = FN_W'(freq1_ff) * FN_W'(stats1_ff.n);
   assign tn = FN_W'(tol_ff) * FN_W'(stats1_ff.n);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         w2_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
         w2_ff <= w1_ff;
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         word2_ff  <= word1_ff;
         stats2_ff <= stats1_ff;
         nq2_ff    <= nq;
         ss2_ff    <= ss;
         fn2_ff    <= fn;
         tn2_ff    <= tn;
      end
   end

   // ---- stage 3: status and output register
   always_comb begin
      lhs         = {fn2_ff, 1'b0};
      rhs         = CROSS_W'({stats2_ff.s, 16'd0});
      bound       = {tn2_ff, 1'b0};
      diff        = (lhs > rhs) ? (lhs - rhs) : (rhs - lhs);
      spread_full = (nq2_ff > ss2_ff) ? (nq2_ff - ss2_ff) : '0;
      priority if (stats2_ff.n == '0) begin
         status = STATUS_ALL_MISSING;
      end else if (diff > bound) begin
         status = STATUS_MISMATCH;
      end else if (spread_full == '0) begin
         status = STATUS_NO_VARIATION;
      end else begin
         status = STATUS_KEPT;
      end
   end

   always_comb begin
      pend_word_in = pend_word_ff;
      pend_sum_in  = pend_sum_ff;
      if (load3) begin
         pend_word_in = w2_ff;
         pend_sum_in  = s2_ff;
      end else if (rsp_accept) begin
         if (pend_word_ff) begin
            pend_word_in = 1'b0;
         end else begin
            pend_sum_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_word_ff <= 1'b0;
         pend_sum_ff  <= 1'b0;
      end else begin
         pend_word_ff <= pend_word_in;
         pend_sum_ff  <= pend_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         word3_ff   <= word2_ff;
         stats3_ff  <= stats2_ff;
         status3_ff <= status;
         spread3_ff <= spread_full[SPREAD_W-1:0];
      end
   end

   // word goes first, summary fields read as zero on a word and vice versa
   assign rsp_result_kind       = pend_word_ff ? KIND_WORD : KIND_SUMMARY;
   assign rsp_final_of_variant  = !pend_word_ff;
   assign rsp_plane_a1_word     = pend_word_ff ? word3_ff.a1  : '0;
   assign rsp_plane_a2_word     = pend_word_ff ? word3_ff.a2  : '0;
   assign rsp_word_number       = pend_word_ff ? word3_ff.num : '0;
   assign rsp_variant_status    = pend_word_ff ? STATUS_KEPT  : status3_ff;
   assign rsp_dosage_sum        = pend_word_ff ? '0 : stats3_ff.s;
   assign rsp_dosage_square_sum = pend_word_ff ? '0 : stats3_ff.q;
   assign rsp_present_count     = pend_word_ff ? '0 : stats3_ff.n;
   assign rsp_spread_value      = pend_word_ff ? '0 : spread3_ff;

endmodule

`default_nettype wire

@@ hw/rtl/gbus_checker.sv @@
`default_nettype none
`include "genotype_byte_unpack_stats_top_defines.svh"

module gbus_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_result_kind,
   input  logic [gbus_pkg::WORD_BITS-1:0]    rsp_plane_a1_word,
   input  logic [gbus_pkg::WORD_BITS-1:0]    rsp_plane_a2_word,
   input  logic [gbus_pkg::WNUM_W-1:0]       rsp_word_number,
   input  logic [gbus_pkg::STATUS_W-1:0]     rsp_variant_status,
   input  logic [gbus_pkg::SUM_W-1:0]        rsp_dosage_sum,
   input  logic [gbus_pkg::SQ_W-1:0]         rsp_dosage_square_sum,
   input  logic [gbus_pkg::CNT_W-1:0]        rsp_present_count,
   input  logic [gbus_pkg::SPREAD_W-1:0]     rsp_spread_value,
   input  logic                              rsp_final_of_variant
);
   import gbus_pkg::*;

   localparam int PAYLOAD_W =
      2 + 2 * WORD_BITS + WNUM_W + STATUS_W + SUM_W + SQ_W + CNT_W + SPREAD_W;

   logic [PAYLOAD_W-1:0] rsp_payload;
   logic                 word_clean;

   assign rsp_payload = {rsp_result_kind, rsp_plane_a1_word, rsp_plane_a2_word,
                         rsp_word_number, rsp_variant_status, rsp_dosage_sum,
                         rsp_dosage_square_sum, rsp_present_count, rsp_spread_value,
                         rsp_final_of_variant};

   assign word_clean = rsp_variant_status == STATUS_KEPT && rsp_dosage_sum == '0 &&
                       rsp_dosage_square_sum == '0 && rsp_present_count == '0 &&
                       rsp_spread_value == '0;

   // stalled result holds
   `GBUS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // only a summary closes a variant
   `GBUS_ASSERT_NOW(a_final_kind, rsp_valid, rsp_final_of_variant == (rsp_result_kind == KIND_SUMMARY))

   // plane words carry no statistics
   `GBUS_ASSERT_NOW(a_word_clean, rsp_valid && rsp_result_kind == KIND_WORD, word_clean)

   // all-missing exactly when nobody was counted
   `GBUS_ASSERT_NOW(a_missing, rsp_valid && rsp_result_kind == KIND_SUMMARY, (rsp_present_count == '0) == (rsp_variant_status == STATUS_ALL_MISSING))

endmodule

bind genotype_byte_unpack_stats_top gbus_checker u_gbus_checker (.*);

`default_nettype wire
